// ===== rtl/arm_forward_kinematics_macros.svh =====
// Assertion macros shared by the checker.
`ifndef ARM_FORWARD_KINEMATICS_MACROS_SVH
`define ARM_FORWARD_KINEMATICS_MACROS_SVH
// Assert that an implication holds on every clock edge outside reset.
`define AFK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assert a property that is also checked during reset.
`define AFK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/afk_pkg.sv =====
// Shared constants, register indexes and the sine polynomial for the kinematics pipeline.
package afk_pkg;
  localparam int OUT_BITS = 27;
  localparam int REG_IDX_BITS = 3;
  localparam int TRIG_BITS = 17;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_BASE_HEIGHT = 3'd0,
    REG_SHOULDER_D  = 3'd1,
    REG_ELBOW_D     = 3'd2,
    REG_UPPER_ARM   = 3'd3,
    REG_FOREARM     = 3'd4,
    REG_SHLD_BIAS   = 3'd5
  } reg_idx_t;

  localparam logic [16:0] SIN_A = 17'd51472;
  localparam logic [16:0] SIN_B = 17'd21024;
  localparam logic [16:0] SIN_C = 17'd2320;
  localparam logic [14:0] HALF_Q15 = 15'd16384;

  // Folded Q15 fraction (0..32768) from the top 17 phase bits.
  function automatic logic [15:0] fold_frac(input logic [16:0] ph);
    logic [15:0] x;
    x = {1'b0, ph[14:0]};
    if (ph[15]) x = 16'd32768 - x;
    return x;
  endfunction

  // Sign and clamp of the sine magnitude (Q15), giving a signed 17-bit value.
  function automatic logic signed [16:0] sine_sign(input logic [16:0] mag, input logic neg);
    logic [15:0] m;
    m = (mag > 17'd32767) ? 16'd32767 : mag[15:0];
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction
endpackage

// ===== rtl/afk_sine.sv =====
// Pipelined sine polynomial: four multiply stages, one phase in per cycle while en is high.
module afk_sine (
  input  logic               clk,
  input  logic               en,
  input  logic [16:0]        phase,
  output logic signed [16:0] sine
);
  import afk_pkg::*;

  logic [15:0] x0, x1, x2r, x3;
  logic [1:0]  q0, q1, q2, q3;
  logic [16:0] sq1, sq2, t1, t2;
  logic [33:0] p_sq, p_c, p_t, p_s;

  assign p_sq = {18'd0, x0} * {18'd0, x0};
  assign p_c  = {17'd0, sq1} * {17'd0, SIN_C};
  assign p_t  = {17'd0, sq2} * {17'd0, t1};
  assign p_s  = {18'd0, x3} * {17'd0, t2};

  always_ff @(posedge clk) begin
    if (en) begin
      x0  <= fold_frac(phase);
      q0  <= phase[16:15];
      sq1 <= 17'((p_sq + 34'(HALF_Q15)) >> 15);
      x1  <= x0;
      q1  <= q0;
      t1  <= SIN_B - 17'((p_c + 34'(HALF_Q15)) >> 15);
      sq2 <= sq1;
      x2r <= x1;
      q2  <= q1;
      t2  <= SIN_A - 17'((p_t + 34'(HALF_Q15)) >> 15);
      x3  <= x2r;
      q3  <= q2;
      sine <= sine_sign(17'((p_s + 34'(HALF_Q15)) >> 15), q3[1]);
    end
  end
endmodule

// ===== rtl/afk_round.sv =====
// Round-to-nearest (ties away) shift of a signed value, with saturation.
module afk_round #(
  parameter int IN_W  = 64,
  parameter int OUT_W = 27,
  parameter int SHIFT = 15
) (
  input  logic signed [IN_W-1:0]  din,
  output logic signed [OUT_W-1:0] dout
);
  logic [IN_W-1:0] mag, rnd;
  logic signed [IN_W-1:0] v;
  localparam logic signed [IN_W-1:0] HI = (IN_W)'((64'sd1 <<< (OUT_W-1)) - 1);
  localparam logic signed [IN_W-1:0] LO = -HI - 1;

  always_comb begin
    mag = din[IN_W-1] ? -din : din;
    rnd = (mag + (IN_W)'(64'd1 << (SHIFT-1))) >> SHIFT;
    v = din[IN_W-1] ? -$signed(rnd) : $signed(rnd);
    if (v > HI) dout = HI[OUT_W-1:0];
    else if (v < LO) dout = LO[OUT_W-1:0];
    else dout = v[OUT_W-1:0];
  end
endmodule

// ===== rtl/arm_forward_kinematics.sv =====
// Usage: stream-style forward kinematics of a three-joint arm.
// Slave channel s_axis carries {elbow, shoulder, base} angles, one transaction per cycle unless stalled.
// Master channel m_axis carries {pos_z, pos_y, pos_x}, 27 bits each, 0.01 mm units.
// Link geometry is set through cfg_we/cfg_index/cfg_data, which the user must write only while the block
// is idle; the block does not enforce this. Index 0..4 are d1, d2, d3, a2, a3; index 5 is the shoulder angle bias.
// The pipeline has one phase stage, five sine stages, then six arithmetic stages
// (products, rounding and sums; at most four multipliers in a stage, none wider
// than 27 by 17 or 24 by 18 bits); throughput is one transaction per cycle when not stalled.
// The whole pipeline advances as one; when m_axis_tready is low and the output
// register is full, every stage holds, and s_axis_tready falls with it.
// A bubble in the output register is filled even under a stall.
// Reset (rst, synchronous) clears all valid bits and the geometry registers to zero.
module arm_forward_kinematics #(
  parameter int ANGLE_BITS  = 16,
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // base_angle, shoulder_angle, elbow_angle from bit 0
  input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // pos_x, pos_y, pos_z from bit 0
  output logic [87:0]            m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [(LENGTH_BITS > ANGLE_BITS ? LENGTH_BITS : ANGLE_BITS)-1:0] cfg_data
);
  import afk_pkg::*;
  localparam int L = LENGTH_BITS;
  localparam int DEPTH = 12;
  // product and sum widths
  localparam int PW = 2 * 17;         // trig by trig
  localparam int LW = L + 17;         // length by trig
  localparam int MW = 18;             // rounded c2*c3 - s2*s3
  localparam int AW = L + MW;         // a3 by m15
  localparam int ZW = LW + 2;         // z accumulator
  localparam int SW = L + 1;          // d2 + d3
  localparam int RW = OUT_BITS;       // reach
  localparam int XW = RW + 17;        // reach by trig
  localparam int DW = SW + 17;        // dsum by trig
  localparam int OW = XW + 1;         // x, y sums

  logic signed [L-1:0] d1, d2, d3, a2, a3;
  logic [ANGLE_BITS-1:0] bias;
  logic [DEPTH-1:0] vld;
  logic en;

  assign en = !vld[DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d1 <= '0; d2 <= '0; d3 <= '0; a2 <= '0; a3 <= '0; bias <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_HEIGHT: d1 <= cfg_data[L-1:0];
        REG_SHOULDER_D:  d2 <= cfg_data[L-1:0];
        REG_ELBOW_D:     d3 <= cfg_data[L-1:0];
        REG_UPPER_ARM:   a2 <= cfg_data[L-1:0];
        REG_FOREARM:     a3 <= cfg_data[L-1:0];
        REG_SHLD_BIAS:   bias <= cfg_data[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], s_axis_tvalid};
  end

  // Stage 0: phases (top 17 bits of the 32-bit phase, zero-padded below for short angles).
  logic [ANGLE_BITS-1:0] ab, as, ae, p2a, p23a;
  logic [16:0] ph [7];
  function automatic logic [16:0] top17(input logic [ANGLE_BITS-1:0] a);
    logic [31:0] p;
    p = {a, {(32-ANGLE_BITS){1'b0}}};
    return p[31:15];
  endfunction
  assign ab = s_axis_tdata[ANGLE_BITS-1:0];
  assign as = s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS];
  assign ae = s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS];
  assign p2a = as + bias;
  assign p23a = p2a + ae;
  localparam logic [16:0] QTR = 17'h08000;
  always_ff @(posedge clk) begin
    if (en) begin
      ph[0] <= top17(ab);
      ph[1] <= top17(ab) + QTR;
      ph[2] <= top17(p2a);
      ph[3] <= top17(p2a) + QTR;
      ph[4] <= top17(ae);
      ph[5] <= top17(ae) + QTR;
      ph[6] <= top17(p23a);
    end
  end

  logic signed [16:0] sn [7];
  for (genvar g = 0; g < 7; g++) begin : g_sin
    afk_sine u_sin (.clk(clk), .en(en), .phase(ph[g]), .sine(sn[g]));
  end
  // sn: 0 s1, 1 c1, 2 s2, 3 c2, 4 s3, 5 c3, 6 s23 (valid at stage 5 output)

  // Stage 6: c2*c3, s2*s3, a2*s2, a2*c2
  logic signed [PW-1:0] cc, ss;
  logic signed [LW-1:0] a2s2, a2c2;
  logic signed [16:0] s1_6, c1_6, s23_6;
  always_ff @(posedge clk) begin
    if (en) begin
      cc   <= PW'(sn[3]) * PW'(sn[5]);
      ss   <= PW'(sn[2]) * PW'(sn[4]);
      a2s2 <= LW'(a2) * LW'(sn[2]);
      a2c2 <= LW'(a2) * LW'(sn[3]);
      s1_6 <= sn[0]; c1_6 <= sn[1]; s23_6 <= sn[6];
    end
  end

  // Stage 7: m15 rounding; a3*s23
  logic signed [MW-1:0] m15w, m15r;
  logic signed [LW-1:0] a3s23, a2c2_7, a2s2_7;
  logic signed [16:0] s1_7, c1_7;
  afk_round #(.IN_W(PW), .OUT_W(MW), .SHIFT(15)) u_rm (.din(cc - ss), .dout(m15r));
  always_ff @(posedge clk) begin
    if (en) begin
      m15w <= m15r;
      a3s23 <= LW'(a3) * LW'(s23_6);
      a2c2_7 <= a2c2; a2s2_7 <= a2s2;
      s1_7 <= s1_6; c1_7 <= c1_6;
    end
  end

  // Stage 8: a3*m15 and z accumulation
  logic signed [AW-1:0] a3m;
  logic signed [LW-1:0] a2c2_8;
  logic signed [ZW-1:0] zacc;
  logic signed [16:0] s1_8, c1_8;
  always_ff @(posedge clk) begin
    if (en) begin
      a3m <= AW'(a3) * AW'(m15w);
      a2c2_8 <= a2c2_7;
      zacc <= (ZW'(d1) <<< 15) - ZW'(a2s2_7) - ZW'(a3s23);
      s1_8 <= s1_7; c1_8 <= c1_7;
    end
  end

  // Stage 9: reach rounding
  logic signed [RW-1:0] reach, reachr;
  logic signed [ZW-1:0] z9;
  logic signed [SW-1:0] dsum9;
  logic signed [16:0] s1_9, c1_9;
  afk_round #(.IN_W(ZW), .OUT_W(RW), .SHIFT(15)) u_rr (
    .din(ZW'(a2c2_8) + ZW'(a3m)), .dout(reachr)
  );
  always_ff @(posedge clk) begin
    if (en) begin
      reach <= reachr; z9 <= zacc;
      dsum9 <= SW'(d2) + SW'(d3);
      s1_9 <= s1_8; c1_9 <= c1_8;
    end
  end

  // Stage 10: four products
  logic signed [XW-1:0] rc, rs;
  logic signed [DW-1:0] ds, dc;
  logic signed [ZW-1:0] z10;
  always_ff @(posedge clk) begin
    if (en) begin
      rc <= XW'(reach) * XW'(c1_9); ds <= DW'(dsum9) * DW'(s1_9);
      rs <= XW'(reach) * XW'(s1_9); dc <= DW'(dsum9) * DW'(c1_9);
      z10 <= z9;
    end
  end

  // Stage 11: round and saturate into the output register
  logic signed [OUT_BITS-1:0] xo, yo, zo;
  afk_round #(.IN_W(OW), .OUT_W(OUT_BITS), .SHIFT(15)) u_rx (
    .din(OW'(rc) - OW'(ds)), .dout(xo)
  );
  afk_round #(.IN_W(OW), .OUT_W(OUT_BITS), .SHIFT(15)) u_ry (
    .din(OW'(rs) + OW'(dc)), .dout(yo)
  );
  afk_round #(.IN_W(ZW), .OUT_W(OUT_BITS), .SHIFT(15)) u_rz (.din(z10), .dout(zo));
  always_ff @(posedge clk) begin
    if (en) m_axis_tdata <= {7'd0, zo, yo, xo};
  end
endmodule

// ===== rtl/afk_checker.sv =====
// Port-level checker for the kinematics block, bound to the top level.
`include "arm_forward_kinematics_macros.svh"
module afk_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [87:0] m_axis_tdata
);
  `AFK_ASSERT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed under stall")
  `AFK_ASSERT(a_ready, clk, rst, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
  `AFK_ASSERT(a_stall, clk, rst, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken during stall")
  `AFK_ASSERT_ALWAYS(a_rst, clk, rst |=> !m_axis_tvalid, "valid after reset")
endmodule

bind arm_forward_kinematics afk_checker u_afk_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ===== tb/arm_forward_kinematics_test.sv =====
// Self-checking testbench for the three-joint arm forward kinematics pipeline.
module arm_forward_kinematics_test;
  import afk_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [26:0] z;
    logic signed [26:0] y;
    logic signed [26:0] x;
  } tool_pos_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  // Predictor copy of the link geometry.
  logic signed [23:0] geo_d1, geo_d2, geo_d3, geo_a2, geo_a3;
  logic [15:0] geo_bias;

  tool_pos_t pos_queue[$];
  int errors = 0;
  int idle_cycles = 0;
  bit rx_hold = 0;
  bit rx_no_idle = 0;
  bit tx_no_idle = 0;

  arm_forward_kinematics dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint rnd_shift(longint v, int k);
    longint half;
    half = longint'(1) << (k - 1);
    if (v >= 0) return (v + half) >>> k;
    return -((-v + half) >>> k);
  endfunction

  function automatic longint sine_of(logic [31:0] ph);
    longint x, x2, t1, t2, s;
    x = longint'(ph[29:15]);
    if (ph[30]) x = 32768 - x;
    x2 = (x * x + 16384) >>> 15;
    t1 = 21024 - ((x2 * 2320 + 16384) >>> 15);
    t2 = 51472 - ((x2 * t1 + 16384) >>> 15);
    s = (x * t2 + 16384) >>> 15;
    if (s > 32767) s = 32767;
    return ph[31] ? -s : s;
  endfunction

  function automatic logic [26:0] clamp_pos(longint acc);
    longint v;
    v = rnd_shift(acc, 15);
    if (v > 67108863) v = 67108863;
    if (v < -67108864) v = -67108864;
    return v[26:0];
  endfunction

  function automatic tool_pos_t solve_position(logic [15:0] b, logic [15:0] s, logic [15:0] e);
    logic [31:0] p1, p2, p3, p23, qt;
    longint s1, c1, s2, c2, s3, c3, s23, m15, reach, dsum;
    tool_pos_t r;
    qt = 32'h4000_0000;
    p1 = {b, 16'h0};
    p2 = {s, 16'h0} + {geo_bias, 16'h0};
    p3 = {e, 16'h0};
    p23 = p2 + p3;
    s1 = sine_of(p1); c1 = sine_of(p1 + qt);
    s2 = sine_of(p2); c2 = sine_of(p2 + qt);
    s3 = sine_of(p3); c3 = sine_of(p3 + qt);
    s23 = sine_of(p23);
    m15 = rnd_shift(c2 * c3 - s2 * s3, 15);
    reach = rnd_shift(longint'(geo_a2) * c2 + longint'(geo_a3) * m15, 15);
    dsum = longint'(geo_d2) + longint'(geo_d3);
    r.x = clamp_pos(reach * c1 - dsum * s1);
    r.y = clamp_pos(reach * s1 + dsum * c1);
    r.z = clamp_pos(longint'(geo_d1) * 32768 - longint'(geo_a2) * s2
                    - longint'(geo_a3) * s23);
    return r;
  endfunction

  // Receiver: random stalls, a long hold-off when asked.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rx_no_idle || ($urandom_range(99) >= 21);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    tool_pos_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[80:0];
      if (pos_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pos_queue.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t: pos_y expected %0d actual %0d", $time, want.y, got.y);
          errors++;
        end
        if (got.z !== want.z) begin
          $display("%0t: pos_z expected %0d actual %0d", $time, want.z, got.z);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_angles(logic [15:0] b, logic [15:0] s, logic [15:0] e);
    while (!tx_no_idle && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {e, s, b};
    pos_queue.push_back(solve_position(b, s, e));
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pos_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_geometry(reg_idx_t idx, logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BASE_HEIGHT: geo_d1 = v;
      REG_SHOULDER_D:  geo_d2 = v;
      REG_ELBOW_D:     geo_d3 = v;
      REG_UPPER_ARM:   geo_a2 = v;
      REG_FOREARM:     geo_a3 = v;
      REG_SHLD_BIAS:   geo_bias = v[15:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [23:0] d1, logic [23:0] d2, logic [23:0] d3,
                              logic [23:0] a2, logic [23:0] a3, logic [15:0] bias);
    write_geometry(REG_BASE_HEIGHT, d1);
    write_geometry(REG_SHOULDER_D, d2);
    write_geometry(REG_ELBOW_D, d3);
    write_geometry(REG_UPPER_ARM, a2);
    write_geometry(REG_FOREARM, a3);
    // high data bits above the angle width must be dropped
    write_geometry(REG_SHLD_BIAS, {8'hA5, bias});
  endtask

  task automatic test_directed_angles();
    logic [15:0] ang[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                            16'h7FFF, 16'hFFFF, 16'h0001, 16'h2000};
    set_geometry(24'd12000, 24'd1500, -24'sd700, 24'd30000, 24'd25000, 16'h0000);
    for (int i = 0; i < 8; i++) send_angles(ang[i], ang[(i + 3) % 8], ang[(i + 5) % 8]);
    send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_angles(16'h0000, 16'h0000, 16'h0000);
    wait_drained();
    // extreme geometry: every length and the bias at their largest positive values
    set_geometry(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF);
    for (int i = 0; i < 6; i++) send_angles(ang[i], ang[i + 1], ang[i + 2]);
    wait_drained();
    set_geometry(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 16'h8000);
    for (int i = 0; i < 6; i++) send_angles(ang[i + 2], ang[i], ang[i + 1]);
    wait_drained();
  endtask

  task automatic test_random_poses(int n);
    for (int i = 0; i < n; i++) begin
      tx_no_idle = (i % 400) >= 300;
      rx_no_idle = tx_no_idle;
      send_angles(16'($urandom()), 16'($urandom()), 16'($urandom()));
    end
    tx_no_idle = 0;
    rx_no_idle = 0;
    wait_drained();
  endtask

  task automatic test_random_geometry();
    for (int g = 0; g < 4; g++) begin
      set_geometry(24'($urandom()), 24'($urandom()), 24'($urandom()),
                   24'($urandom()), 24'($urandom()), 16'($urandom()));
      test_random_poses(250);
    end
    // realistic arm sizes
    set_geometry(24'($urandom_range(50000)), 24'($urandom_range(5000)),
                 24'($urandom_range(5000)), 24'($urandom_range(80000)),
                 24'($urandom_range(80000)), 16'($urandom()));
    test_random_poses(400);
  endtask

  task automatic test_backpressure();
    int held;
    rx_hold = 1;
    fork
      begin
        for (int i = 0; i < 40; i++)
          send_angles(16'($urandom()), 16'($urandom()), 16'($urandom()));
      end
      begin
        for (held = 0; held < 200; held++) @(posedge clk);
        rx_hold = 0;
      end
    join
    wait_drained();
  endtask

  initial begin
    geo_d1 = '0; geo_d2 = '0; geo_d3 = '0; geo_a2 = '0; geo_a3 = '0; geo_bias = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_angles();
    test_backpressure();
    test_random_geometry();
    test_random_poses(200);
    if (errors == 0 && pos_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
